// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the echo ranger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that the expression holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`endif

`endif

// ===== src/uera_pkg.sv =====
// Types and constants of the ultrasonic echo ranger.
package uera_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int CAPTURE_BITS   = 16;
	localparam int CLOCK_BITS     = 24;
	localparam int DIST_BITS      = 11;

	localparam logic [DIST_BITS-1:0]  DIST_MAX   = 11'd2047;
	localparam logic [CLOCK_BITS-1:0] PERIOD_TOP = 24'h00FFFF;

	localparam logic [9:0]            FAR_RST   = 10'd50;
	localparam logic [9:0]            NEAR_RST  = 10'd30;
	localparam logic [9:0]            CLOSE_RST = 10'd10;
	localparam logic [15:0]           TICKS_RST = 16'd1048;
	localparam logic [15:0]           BASE_RST  = 16'd5000;
	localparam logic [15:0]           SLOPE_RST = 16'd100;
	localparam logic [CLOCK_BITS-1:0] CLOCK_RST = 24'd1048576;

	typedef enum logic [2:0] {
		CFG_FAR_LIMIT    = 3'd0,
		CFG_NEAR_LIMIT   = 3'd1,
		CFG_CLOSE_LIMIT  = 3'd2,
		CFG_TICKS_PER_MS = 3'd3,
		CFG_TONE_BASE    = 3'd4,
		CFG_TONE_SLOPE   = 3'd5,
		CFG_TONE_CLOCK   = 3'd6
	} cfg_reg_t;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DIV_DIST = 7'b0000010,
		ST_SAT      = 7'b0000100,
		ST_MUL      = 7'b0001000,
		ST_FREQ     = 7'b0010000,
		ST_DIV_TONE = 7'b0100000,
		ST_LOAD     = 7'b1000000
	} state_t;

endpackage

// ===== src/ultrasonic_echo_ranger_with_alarm.sv =====
// Ultrasonic echo ranger: pulse width to distance, zone LEDs and buzzer tone setup.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-------------------------------------
//  capture   | in        | capture_valid / _stall  | capture_time
//  result    | out       | result_valid / _stall   | distance_cm, red_led, green_led,
//            |           |                         | tone_hz, tone_period, tone_compare
//  cfg       | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A rising-edge capture only stores its time stamp and gives no result. A falling-edge
// capture runs distance division, saturation, multiply, frequency, tone division, load;
// every cycle of the two divisions is one restoring step of the single shared divider,
// first the distance, then the tone period. A silent tone skips the second division.
// While a capture is in work, capture_stall is high. A finished result sits in the
// output register; the next capture is taken while it waits, and only the final load of
// a new result waits for result_stall to drop. Reset returns the control and configuration
// registers to their defaults (not the datapath registers) and expects a rising edge next.
`include "assert_macros.svh"

module ultrasonic_echo_ranger_with_alarm #(
	parameter int TIMER_BITS = uera_pkg::TIMER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                capture_valid,
	output logic                                capture_stall,
	input  logic [uera_pkg::CAPTURE_BITS-1:0]   capture_time,

	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [uera_pkg::DIST_BITS-1:0]      distance_cm,
	output logic                                red_led,
	output logic                                green_led,
	output logic [15:0]                         tone_hz,
	output logic [15:0]                         tone_period,
	output logic [14:0]                         tone_compare,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [2:0]                          cfg_index,
	input  logic [uera_pkg::CLOCK_BITS-1:0]     cfg_data
);

	// Stamp bits that actually reach the timer compare.
	localparam int SB = (TIMER_BITS < uera_pkg::CAPTURE_BITS) ?
		TIMER_BITS : uera_pkg::CAPTURE_BITS;
	// Dividend width of the distance division: width * 17 needs five more bits.
	localparam int N1 = TIMER_BITS + 5;
	localparam int N2 = uera_pkg::CLOCK_BITS;
	// Shift register width of the shared divider.
	localparam int DW = (N1 > N2) ? N1 : N2;
	localparam int CW = $clog2(DW + 1);

	// Configuration registers.
	logic [9:0]                         far_q;
	logic [9:0]                         near_q;
	logic [9:0]                         close_q;
	logic [15:0]                        ticks_q;
	logic [15:0]                        base_q;
	logic [15:0]                        slope_q;
	logic [uera_pkg::CLOCK_BITS-1:0]    clock_q;

	// Edge tracking.
	logic                               await_q;
	logic [SB-1:0]                      rise_q;

	// Sequencer and shared divider.
	uera_pkg::state_t                   state_q;
	logic [CW-1:0]                      cnt_q;
	logic [DW-1:0]                      dq_q;
	logic [15:0]                        rem_q;
	logic [15:0]                        div_q;

	// Intermediate results.
	logic [uera_pkg::DIST_BITS-1:0]     dist_q;
	logic [26:0]                        prod_q;
	logic                               far_hit_q;
	logic                               red_q;
	logic                               green_q;
	logic [15:0]                        freq_q;

	// Output register.
	logic                               out_valid_q;
	logic [uera_pkg::DIST_BITS-1:0]     out_dist_q;
	logic                               out_red_q;
	logic                               out_green_q;
	logic [15:0]                        out_freq_q;
	logic [15:0]                        out_period_q;

	logic                               cap_take;
	logic                               out_free;
	logic [TIMER_BITS-1:0]              stamp_w;
	logic [TIMER_BITS-1:0]              rise_w;
	logic [TIMER_BITS-1:0]              width_w;
	logic [N1-1:0]                      width17_w;
	logic [15:0]                        ticks_w;
	logic [16:0]                        rem_sh_w;
	logic                               ge_w;
	logic [16:0]                        rem_diff_w;
	logic [15:0]                        rem_nx_w;
	logic [uera_pkg::DIST_BITS-1:0]     dist_sat_w;
	logic [26:0]                        prod_w;
	logic [15:0]                        freq_w;
	logic [uera_pkg::CLOCK_BITS-1:0]    quot_w;
	logic [15:0]                        period_w;

	assign cfg_ready     = 1'b1;
	assign capture_stall = (state_q != uera_pkg::ST_IDLE);
	assign cap_take      = capture_valid && !capture_stall;
	// The output slot can take a new result when empty or being drained.
	assign out_free      = !out_valid_q || !result_stall;

	// Pulse width modulo the timer range; wrap falls out of the subtraction.
	assign stamp_w   = TIMER_BITS'(capture_time[SB-1:0]);
	assign rise_w    = TIMER_BITS'(rise_q);
	assign width_w   = stamp_w - rise_w;
	assign width17_w = (N1'(width_w) << 4) + N1'(width_w);
	// Guard a zero tick rate.
	assign ticks_w   = (ticks_q == 16'd0) ? 16'd1 : ticks_q;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	assign rem_sh_w   = {rem_q, dq_q[DW-1]};
	assign ge_w       = (rem_sh_w >= {1'b0, div_q});
	assign rem_diff_w = rem_sh_w - {1'b0, div_q};
	assign rem_nx_w   = ge_w ? rem_diff_w[15:0] : rem_sh_w[15:0];

	// Saturate the distance quotient to eleven bits.
	assign dist_sat_w = (|dq_q[N1-1:uera_pkg::DIST_BITS]) ?
		uera_pkg::DIST_MAX : dq_q[uera_pkg::DIST_BITS-1:0];

	assign prod_w = slope_q * dist_q;

	// Clamp the tone at zero; silence it beyond the far limit.
	assign freq_w = (far_hit_q || (prod_q >= {11'd0, base_q})) ? 16'd0 :
		(base_q - prod_q[15:0]);

	// Period is quotient minus one, kept only for quotients 1 through 0xFFFF.
	assign quot_w   = dq_q[uera_pkg::CLOCK_BITS-1:0];
	assign period_w = ((quot_w != '0) && (quot_w <= uera_pkg::PERIOD_TOP)) ?
		(quot_w[15:0] - 16'd1) : 16'd0;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_q   <= uera_pkg::FAR_RST;
			near_q  <= uera_pkg::NEAR_RST;
			close_q <= uera_pkg::CLOSE_RST;
			ticks_q <= uera_pkg::TICKS_RST;
			base_q  <= uera_pkg::BASE_RST;
			slope_q <= uera_pkg::SLOPE_RST;
			clock_q <= uera_pkg::CLOCK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				uera_pkg::CFG_FAR_LIMIT:    far_q   <= cfg_data[9:0];
				uera_pkg::CFG_NEAR_LIMIT:   near_q  <= cfg_data[9:0];
				uera_pkg::CFG_CLOSE_LIMIT:  close_q <= cfg_data[9:0];
				uera_pkg::CFG_TICKS_PER_MS: ticks_q <= cfg_data[15:0];
				uera_pkg::CFG_TONE_BASE:    base_q  <= cfg_data[15:0];
				uera_pkg::CFG_TONE_SLOPE:   slope_q <= cfg_data[15:0];
				uera_pkg::CFG_TONE_CLOCK:   clock_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uera_pkg::ST_IDLE;
			await_q     <= 1'b1;
			rise_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the slot once drained, unless a new result loads in the same cycle.
			if (out_valid_q && !result_stall && (state_q != uera_pkg::ST_LOAD)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				uera_pkg::ST_IDLE: begin
					if (cap_take) begin
						await_q <= !await_q;
						if (await_q) begin
							rise_q <= capture_time[SB-1:0];
						end else begin
							cnt_q   <= CW'(N1);
							state_q <= uera_pkg::ST_DIV_DIST;
						end
					end
				end
				uera_pkg::ST_DIV_DIST: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= uera_pkg::ST_SAT;
					end
				end
				uera_pkg::ST_SAT: begin
					state_q <= uera_pkg::ST_MUL;
				end
				uera_pkg::ST_MUL: begin
					state_q <= uera_pkg::ST_FREQ;
				end
				uera_pkg::ST_FREQ: begin
					if (freq_w == 16'd0) begin
						state_q <= uera_pkg::ST_LOAD;
					end else begin
						cnt_q   <= CW'(N2);
						state_q <= uera_pkg::ST_DIV_TONE;
					end
				end
				uera_pkg::ST_DIV_TONE: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= uera_pkg::ST_LOAD;
					end
				end
				uera_pkg::ST_LOAD: begin
					// Hold until the output slot frees up.
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= uera_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= uera_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			uera_pkg::ST_IDLE: begin
				// Load the distance division: width * 17 over ticks per ms.
				if (cap_take && !await_q) begin
					dq_q  <= DW'(width17_w) << (DW - N1);
					rem_q <= '0;
					div_q <= ticks_w;
				end
			end
			uera_pkg::ST_DIV_DIST, uera_pkg::ST_DIV_TONE: begin
				dq_q  <= {dq_q[DW-2:0], ge_w};
				rem_q <= rem_nx_w;
			end
			uera_pkg::ST_SAT: begin
				dist_q <= dist_sat_w;
			end
			uera_pkg::ST_MUL: begin
				prod_q    <= prod_w;
				far_hit_q <= (dist_q > {1'b0, far_q});
				// Zones in fixed order: above far, near..far, close..near, below close.
				if (dist_q > {1'b0, far_q}) begin
					red_q   <= 1'b0;
					green_q <= 1'b0;
				end else if (dist_q >= {1'b0, near_q}) begin
					red_q   <= 1'b0;
					green_q <= 1'b1;
				end else if (dist_q >= {1'b0, close_q}) begin
					red_q   <= 1'b1;
					green_q <= 1'b0;
				end else begin
					red_q   <= 1'b1;
					green_q <= 1'b1;
				end
			end
			uera_pkg::ST_FREQ: begin
				freq_q <= freq_w;
				rem_q  <= '0;
				div_q  <= freq_w;
				// A silent tone leaves a zero quotient, which maps to a zero period.
				if (freq_w == 16'd0) begin
					dq_q <= '0;
				end else begin
					dq_q <= DW'(clock_q) << (DW - N2);
				end
			end
			uera_pkg::ST_LOAD: begin
				if (out_free) begin
					out_dist_q   <= dist_q;
					out_red_q    <= red_q;
					out_green_q  <= green_q;
					out_freq_q   <= freq_q;
					out_period_q <= period_w;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign distance_cm  = out_dist_q;
	assign red_led      = out_red_q;
	assign green_led    = out_green_q;
	assign tone_hz      = out_freq_q;
	assign tone_period  = out_period_q;
	assign tone_compare = out_period_q[15:1];

	// The divider always has steps left while a division runs.
	`ASSERT_IMPLIES(a_div_count, clk, arst_n,
		(state_q == uera_pkg::ST_DIV_DIST) || (state_q == uera_pkg::ST_DIV_TONE),
		cnt_q != '0)
	// A silent tone never carries a period.
	`ASSERT_IMPLIES(a_silent_period, clk, arst_n,
		result_valid && (tone_hz == 16'd0), tone_period == 16'd0)
	// Both LEDs off means beyond the far limit, where the buzzer is off too.
	`ASSERT_IMPLIES(a_far_silent, clk, arst_n,
		result_valid && !red_led && !green_led, tone_hz == 16'd0)
	// Duty compare is half the period.
	`ASSERT_IMPLIES(a_half_period, clk, arst_n,
		result_valid, tone_compare == tone_period[15:1])

endmodule
